// File: hw/rtl/daq_frame_sequence_monitor_defines.svh
// assertion macros shared by the frame sequence monitor
`ifndef DAQ_FRAME_SEQUENCE_MONITOR_DEFINES_SVH
`define DAQ_FRAME_SEQUENCE_MONITOR_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define DFSM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dfsm assertion failed");

// next-cycle implication, held off while reset is low
`define DFSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dfsm assertion failed");

`endif

// File: hw/rtl/dfsm_pkg.sv
// ----------------------------------------------------------------------------
// dfsm_pkg
// Constants, queue entry type and saturating counter helpers of the frame
// sequence monitor.
// ----------------------------------------------------------------------------
package dfsm_pkg;

    localparam logic [15:0] SOF_WORD    = 16'h1230;
    localparam int          TT_TMO_BIT  = 15;
    localparam logic [15:0] END_MASK    = 16'h10ff;
    localparam logic [15:0] END_VALUE   = 16'h10fb;
    localparam logic [15:0] CHECK_VALUE = 16'h9876;
    localparam logic [31:0] CNT_MAX     = 32'hffff_ffff;

    // one classified frame waiting for the back end
    typedef struct packed {
        logic        hdr_err;
        logic        id_err;
        logic        tmo;
        logic        trl_err;
        logic [63:0] frame_number;
        logic [63:0] frame_timestamp;
    } t_task;

    // increment that sticks at full scale
    function automatic logic [31:0] sat_inc(input logic [31:0] cnt, input logic en);
        logic [31:0] res;
        res = cnt;
        if (en && (cnt != CNT_MAX)) begin
            res = cnt + 32'd1;
        end
        return res;
    endfunction

    // sum that sticks at full scale
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        logic [31:0] res;
        sum = {1'b0, a} + {1'b0, b};
        res = sum[32] ? CNT_MAX : sum[31:0];
        return res;
    endfunction

endpackage

// File: hw/rtl/daq_fsm_if.sv
// ----------------------------------------------------------------------------
// daq_fsm_if
// Valid/ready channels of the frame sequence monitor: decoded frame fields
// in, check results and totals out.
// ----------------------------------------------------------------------------
interface daq_fsm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] start_word;
    logic [6:0]  frontend_id;
    logic [63:0] frame_number;
    logic [15:0] trigger_status;
    logic [63:0] frame_timestamp;
    logic [15:0] end_word;
    logic [15:0] check_word;

    modport source (
        output valid, start_word, frontend_id, frame_number, trigger_status,
               frame_timestamp, end_word, check_word,
        input  ready
    );
    modport sink (
        input  valid, start_word, frontend_id, frame_number, trigger_status,
               frame_timestamp, end_word, check_word,
        output ready
    );
endinterface

interface daq_fsm_out_if;
    logic               valid;
    logic               ready;
    logic               header_error;
    logic               id_error;
    logic               trigger_timeout;
    logic               trailer_error;
    logic [31:0]        frames_missing;
    logic signed [63:0] time_delta;
    logic [31:0]        frames_total;
    logic [31:0]        header_errors_total;
    logic [31:0]        id_errors_total;
    logic [31:0]        lost_total;
    logic [31:0]        single_losses_total;
    logic [31:0]        timeouts_total;

    modport source (
        output valid, header_error, id_error, trigger_timeout, trailer_error,
               frames_missing, time_delta, frames_total, header_errors_total,
               id_errors_total, lost_total, single_losses_total, timeouts_total,
        input  ready
    );
    modport sink (
        input  valid, header_error, id_error, trigger_timeout, trailer_error,
               frames_missing, time_delta, frames_total, header_errors_total,
               id_errors_total, lost_total, single_losses_total, timeouts_total,
        output ready
    );
endinterface

// File: hw/rtl/dfsm_front.sv
// ----------------------------------------------------------------------------
// dfsm_front
// Accepts frame requests, holds the expected front-end id and classifies
// each frame's header, id, trigger and trailer words for the back end.
// ----------------------------------------------------------------------------
module dfsm_front import dfsm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    daq_fsm_in_if.sink   i_frame,
    input  logic         i_queue_full,
    output logic         o_push,
    output t_task        o_task
);

    logic [6:0] r_exp_id;

    // expected id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_id <= 7'd0;
        end else if (i_cfg_we) begin
            r_exp_id <= i_cfg_wdata;
        end
    end

    // take a request whenever the queue has room
    assign i_frame.ready = !i_queue_full;
    assign o_push        = i_frame.valid && !i_queue_full;

    // classification
    always_comb begin
        o_task.hdr_err         = (i_frame.start_word != SOF_WORD);
        o_task.id_err          = (i_frame.frontend_id != r_exp_id);
        o_task.tmo             = (i_frame.frontend_id == r_exp_id)
                                 && i_frame.trigger_status[TT_TMO_BIT];
        o_task.trl_err         = !(((i_frame.end_word & END_MASK) == END_VALUE)
                                   && (i_frame.check_word == CHECK_VALUE));
        o_task.frame_number    = i_frame.frame_number;
        o_task.frame_timestamp = i_frame.frame_timestamp;
    end

endmodule

// File: hw/rtl/dfsm_queue.sv
// ----------------------------------------------------------------------------
// dfsm_queue
// Short first-in first-out queue of classified frames between the front
// and back ends.
// ----------------------------------------------------------------------------
`include "daq_frame_sequence_monitor_defines.svh"

module dfsm_queue import dfsm_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_task,
    output logic  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_task         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_task  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `DFSM_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `DFSM_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, o_empty, !i_pop)
    `DFSM_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, o_full, !i_push)

endmodule

// File: hw/rtl/dfsm_back.sv
// ----------------------------------------------------------------------------
// dfsm_back
// Carries out the sequence and timestamp tracking of classified frames,
// keeps the saturating totals and holds the result register.
// ----------------------------------------------------------------------------
`include "daq_frame_sequence_monitor_defines.svh"

module dfsm_back import dfsm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_task         i_task,
    input  logic          i_empty,
    output logic          o_pop,
    daq_fsm_out_if.source o_result
);

    logic [63:0] r_last_fn;
    logic [63:0] r_last_ts;
    logic        r_have_match;
    logic        r_have_any;
    logic [31:0] r_cnt_frames;
    logic [31:0] r_cnt_hdr;
    logic [31:0] r_cnt_id;
    logic [31:0] r_cnt_lost;
    logic [31:0] r_cnt_single;
    logic [31:0] r_cnt_tmo;
    logic        r_out_valid;
    logic        r_hdr_err;
    logic        r_id_err;
    logic        r_tmo;
    logic        r_trl_err;
    logic [31:0] r_missing;
    logic [63:0] r_delta;

    logic        take;
    logic        advance;
    logic [63:0] gap_full;
    logic [31:0] n_missing;
    logic [63:0] n_delta;

    // pop the queue when the result register is free or being emptied
    assign take  = !i_empty && (!r_out_valid || o_result.ready);
    assign o_pop = take;

    // frame gap and timestamp difference
    always_comb begin
        advance   = !i_task.id_err && r_have_match && (i_task.frame_number > r_last_fn);
        gap_full  = i_task.frame_number - r_last_fn - 64'd1;
        n_missing = '0;
        if (advance) begin
            n_missing = (gap_full[63:32] != '0) ? CNT_MAX : gap_full[31:0];
        end
        n_delta = r_have_any ? (i_task.frame_timestamp - r_last_ts) : 64'd0;
    end

    // history, totals and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_fn    <= '0;
            r_last_ts    <= '0;
            r_have_match <= 1'b0;
            r_have_any   <= 1'b0;
            r_cnt_frames <= '0;
            r_cnt_hdr    <= '0;
            r_cnt_id     <= '0;
            r_cnt_lost   <= '0;
            r_cnt_single <= '0;
            r_cnt_tmo    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                r_out_valid  <= 1'b1;
                r_last_ts    <= i_task.frame_timestamp;
                r_have_any   <= 1'b1;
                if (!i_task.id_err) begin
                    r_last_fn    <= i_task.frame_number;
                    r_have_match <= 1'b1;
                end
                r_cnt_frames <= sat_inc(r_cnt_frames, 1'b1);
                r_cnt_hdr    <= sat_inc(r_cnt_hdr, i_task.hdr_err);
                r_cnt_id     <= sat_inc(r_cnt_id, i_task.id_err);
                r_cnt_tmo    <= sat_inc(r_cnt_tmo, i_task.tmo);
                r_cnt_single <= sat_inc(r_cnt_single, n_missing == 32'd1);
                r_cnt_lost   <= sat_add(r_cnt_lost, n_missing);
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hdr_err <= i_task.hdr_err;
            r_id_err  <= i_task.id_err;
            r_tmo     <= i_task.tmo;
            r_trl_err <= i_task.trl_err;
            r_missing <= n_missing;
            r_delta   <= n_delta;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.header_error        = r_hdr_err;
    assign o_result.id_error            = r_id_err;
    assign o_result.trigger_timeout     = r_tmo;
    assign o_result.trailer_error       = r_trl_err;
    assign o_result.frames_missing      = r_missing;
    assign o_result.time_delta          = r_delta;
    assign o_result.frames_total        = r_cnt_frames;
    assign o_result.header_errors_total = r_cnt_hdr;
    assign o_result.id_errors_total     = r_cnt_id;
    assign o_result.lost_total          = r_cnt_lost;
    assign o_result.single_losses_total = r_cnt_single;
    assign o_result.timeouts_total      = r_cnt_tmo;

    `DFSM_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n, take, r_out_valid)
    `DFSM_ASSERT_IMPL(a_lost_covers_single, i_clk, i_rst_n, 1'b1, r_cnt_lost >= r_cnt_single)
    `DFSM_ASSERT_IMPL(a_tmo_needs_id, i_clk, i_rst_n, r_out_valid && r_tmo,
                      !r_id_err && (r_missing == '0 || !r_id_err))

endmodule

// File: hw/rtl/daq_frame_sequence_monitor.sv
// ----------------------------------------------------------------------------
// daq_frame_sequence_monitor
// Checks decoded acquisition frame fields and tracks frame continuity,
// timestamp differences and saturating error totals.
// ----------------------------------------------------------------------------
// One frame request is taken per clock cycle while the queue has room: the
// front end classifies the frame as it is taken, a short queue of
// QUEUE_DEPTH entries holds it, and the back end updates the frame-number
// history, the timestamp and the totals into the result register, so a
// steady stream runs at one frame per cycle while the result side does not
// stall. The 64-bit gap and timestamp subtractions in the back end set the
// clock period. The queue absorbs stalls on the result side; once it is
// full the frame channel's ready drops. The expected front-end id may be
// written only while no frame is in flight.
module daq_frame_sequence_monitor import dfsm_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_wdata,
    daq_fsm_in_if.sink    i_frame,
    daq_fsm_out_if.source o_result
);

    t_task q_in;
    t_task q_out;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    // classification
    dfsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_frame      (i_frame),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_task       (q_in)
    );

    // decoupling queue
    dfsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_task  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_task  (q_out),
        .o_empty (q_empty)
    );

    // tracking and totals
    dfsm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_task   (q_out),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_result (o_result)
    );

endmodule

// File: sim/daq_frame_sequence_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daq_frame_sequence_monitor_tb
// Sends decoded frame requests with random gaps on both channels and
// compares every result with a local prediction of the check flags, the
// frame gap, the timestamp difference and the saturating totals.
// ----------------------------------------------------------------------------
module daq_frame_sequence_monitor_tb import dfsm_pkg::*; ();

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_CHUNK = 280;

    // one decoded frame request
    typedef struct packed {
        logic [15:0] start_word;
        logic [6:0]  frontend_id;
        logic [63:0] frame_number;
        logic [15:0] trigger_status;
        logic [63:0] frame_timestamp;
        logic [15:0] end_word;
        logic [15:0] check_word;
    } t_frame_req;

    // flags and totals that one frame should produce
    typedef struct packed {
        logic        hdr_err;
        logic        id_err;
        logic        tmo;
        logic        trl_err;
        logic [31:0] missing;
        logic [63:0] delta;
        logic [31:0] frames;
        logic [31:0] hdr_errs;
        logic [31:0] id_errs;
        logic [31:0] lost;
        logic [31:0] single_losses;
        logic [31:0] timeouts;
    } t_frame_verdict;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [6:0] i_cfg_wdata = '0;

    logic       frame_valid  = 1'b0;
    logic       frame_taken  = 1'b0;
    logic       result_ready = 1'b0;
    t_frame_req frame_on_bus = '0;

    t_frame_req     pending_frames[$];
    t_frame_verdict expected_verdicts[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_cycles  = 0;
    int unsigned mismatch_count = 0;

    // local copy of the block state
    logic [6:0]  fe_id_setting    = '0;
    logic [63:0] last_matching_no = '0;
    logic        have_matching    = 1'b0;
    logic [63:0] last_stamp       = '0;
    logic        have_stamp       = 1'b0;
    logic [31:0] tot_frames       = '0;
    logic [31:0] tot_hdr          = '0;
    logic [31:0] tot_id           = '0;
    logic [31:0] tot_lost         = '0;
    logic [31:0] tot_single       = '0;
    logic [31:0] tot_timeouts     = '0;

    // sequence state of the random frame source
    logic [63:0] gen_frame_no = '0;
    logic [63:0] gen_stamp    = '0;

    daq_fsm_in_if  frame_if ();
    daq_fsm_out_if result_if ();

    assign frame_if.valid           = frame_valid;
    assign frame_if.start_word      = frame_on_bus.start_word;
    assign frame_if.frontend_id     = frame_on_bus.frontend_id;
    assign frame_if.frame_number    = frame_on_bus.frame_number;
    assign frame_if.trigger_status  = frame_on_bus.trigger_status;
    assign frame_if.frame_timestamp = frame_on_bus.frame_timestamp;
    assign frame_if.end_word        = frame_on_bus.end_word;
    assign frame_if.check_word      = frame_on_bus.check_word;
    assign result_if.ready          = result_ready;

    daq_frame_sequence_monitor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_frame     (frame_if),
        .o_result    (result_if)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] sat_bump(input logic [31:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + 32'd1;
    endfunction

    // update the local state with one frame and give its expected result
    task automatic predict_frame(input t_frame_req f, output t_frame_verdict v);
        logic [63:0] gap;
        logic [64:0] lost_sum;
        gap       = '0;
        v.hdr_err = (f.start_word != SOF_WORD);
        v.id_err  = (f.frontend_id != fe_id_setting);
        v.tmo     = 1'b0;
        v.delta   = have_stamp ? f.frame_timestamp - last_stamp : 64'd0;
        last_stamp = f.frame_timestamp;
        have_stamp = 1'b1;

        if (v.hdr_err) begin
            tot_hdr = sat_bump(tot_hdr);
        end
        if (v.id_err) begin
            tot_id = sat_bump(tot_id);
        end else begin
            if (f.trigger_status[TT_TMO_BIT]) begin
                v.tmo        = 1'b1;
                tot_timeouts = sat_bump(tot_timeouts);
            end
            // continuity only once a matching frame has been seen
            if (have_matching && (f.frame_number > last_matching_no)) begin
                gap = f.frame_number - last_matching_no - 64'd1;
                if (gap == 64'd1) begin
                    tot_single = sat_bump(tot_single);
                end
                lost_sum = {33'd0, tot_lost} +
                           ((gap > {32'd0, CNT_MAX}) ? {33'd0, CNT_MAX} : {1'b0, gap});
                tot_lost = (lost_sum > {33'd0, CNT_MAX}) ? CNT_MAX : lost_sum[31:0];
            end
            last_matching_no = f.frame_number;
            have_matching    = 1'b1;
        end
        tot_frames = sat_bump(tot_frames);

        v.trl_err = !(((f.end_word & END_MASK) == END_VALUE) && (f.check_word == CHECK_VALUE));
        v.missing       = (gap > {32'd0, CNT_MAX}) ? CNT_MAX : gap[31:0];
        v.frames        = tot_frames;
        v.hdr_errs      = tot_hdr;
        v.id_errs       = tot_id;
        v.lost          = tot_lost;
        v.single_losses = tot_single;
        v.timeouts      = tot_timeouts;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic queue_frame(input logic [15:0] sw, input logic [6:0] fe,
                               input logic [63:0] fn, input logic [15:0] tt,
                               input logic [63:0] ts, input logic [15:0] ew,
                               input logic [15:0] cw);
        t_frame_req f;
        f.start_word      = sw;
        f.frontend_id     = fe;
        f.frame_number    = fn;
        f.trigger_status  = tt;
        f.frame_timestamp = ts;
        f.end_word        = ew;
        f.check_word      = cw;
        pending_frames = {pending_frames, f};
    endtask

    // mostly well-formed frames running in sequence, with some noise
    task automatic make_random_frame(output t_frame_req f);
        int unsigned pick;
        int unsigned back;
        logic [63:0] wide;
        logic        matching;
        f.start_word  = ($urandom_range(99) < 10) ? 16'($urandom) : SOF_WORD;
        f.frontend_id = ($urandom_range(99) < 20) ? 7'($urandom) : fe_id_setting;
        matching      = (f.frontend_id == fe_id_setting);

        pick = $urandom_range(99);
        back = $urandom_range(0, 8);
        wide = {$urandom, $urandom};
        if (!matching) begin
            f.frame_number = wide;
        end else begin
            // stay clear of huge forward jumps so the lost total keeps moving
            if (pick < 70) begin
                f.frame_number = gen_frame_no + 64'd1;
            end else if (pick < 80) begin
                f.frame_number = gen_frame_no + 64'd2;
            end else if (pick < 88) begin
                f.frame_number = gen_frame_no + 64'($urandom_range(3, 12));
            end else if (pick < 96) begin
                f.frame_number = (gen_frame_no >= 64'(back)) ? gen_frame_no - 64'(back) : '0;
            end else begin
                f.frame_number = (wide <= gen_frame_no) ? wide : gen_frame_no;
            end
            gen_frame_no = f.frame_number;
        end

        f.trigger_status = 16'($urandom);
        if ($urandom_range(99) < 92) begin
            f.frame_timestamp = gen_stamp + 64'($urandom_range(0, 2000));
        end else begin
            f.frame_timestamp = {$urandom, $urandom};
        end
        gen_stamp = f.frame_timestamp;

        if ($urandom_range(99) < 85) begin
            f.end_word = (16'($urandom) & ~END_MASK) | END_VALUE;
        end else begin
            f.end_word = 16'($urandom);
        end
        f.check_word = ($urandom_range(99) < 90) ? CHECK_VALUE : 16'($urandom);
    endtask

    // hold off until every request has gone and every result has come
    task automatic drain_frames();
        while (pending_frames.size() != 0 || frame_valid || expected_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_random(input int unsigned count);
        t_frame_req f;
        repeat (count) begin
            make_random_frame(f);
            pending_frames = {pending_frames, f};
        end
        drain_frames();
    endtask

    task automatic write_fe_id(input logic [6:0] id);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= id;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        fe_id_setting = id;
        @(posedge i_clk);
    endtask

    // frame request driver
    always @(negedge i_clk) begin : frame_driver
        if (i_rst_n && (!frame_valid || frame_taken)) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                frame_on_bus <= pending_frames.pop_front();
                frame_valid  <= 1'b1;
            end else begin
                frame_valid <= 1'b0;
            end
        end
    end

    // result back pressure
    always @(negedge i_clk) begin : result_sink
        result_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // prediction on accepted requests, checking on accepted results
    always @(posedge i_clk) begin : result_monitor
        t_frame_verdict fresh;
        t_frame_verdict want;
        logic           in_fire;
        logic           out_fire;
        in_fire  = i_rst_n && frame_if.valid && frame_if.ready;
        out_fire = i_rst_n && result_if.valid && result_if.ready;
        frame_taken <= in_fire;

        if (in_fire) begin
            predict_frame(frame_on_bus, fresh);
            expected_verdicts = {expected_verdicts, fresh};
        end

        if (out_fire) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result with no frame request outstanding");
            end else begin
                want = expected_verdicts.pop_front();
                check_field("header_error", 64'(result_if.header_error), 64'(want.hdr_err));
                check_field("id_error", 64'(result_if.id_error), 64'(want.id_err));
                check_field("trigger_timeout", 64'(result_if.trigger_timeout),
                            64'(want.tmo));
                check_field("trailer_error", 64'(result_if.trailer_error),
                            64'(want.trl_err));
                check_field("frames_missing", 64'(result_if.frames_missing),
                            64'(want.missing));
                check_field("time_delta", 64'(result_if.time_delta), want.delta);
                check_field("frames_total", 64'(result_if.frames_total), 64'(want.frames));
                check_field("header_errors_total", 64'(result_if.header_errors_total),
                            64'(want.hdr_errs));
                check_field("id_errors_total", 64'(result_if.id_errors_total),
                            64'(want.id_errs));
                check_field("lost_total", 64'(result_if.lost_total), 64'(want.lost));
                check_field("single_losses_total", 64'(result_if.single_losses_total),
                            64'(want.single_losses));
                check_field("timeouts_total", 64'(result_if.timeouts_total),
                            64'(want.timeouts));
            end
        end

        stall_cycles <= (in_fire || out_fire || !i_rst_n) ? 0 : stall_cycles + 1;
    end

    // watchdog on a stalled run
    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // phase one: sparse gaps on requests, heavy back pressure
        send_idle_pct = 19;
        recv_idle_pct = 79;
        write_fe_id(7'h00);

        // first frame of all and first matching frame, near the top of the range
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fff0, 16'h0000, 64'd0,
                    END_VALUE, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fff1, 16'h0000, 64'd100,
                    END_VALUE, CHECK_VALUE);
        // one frame skipped, trigger timeout
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fff3, 16'h8000, 64'd250,
                    END_VALUE, CHECK_VALUE);
        // repeated number, timeout bit clear with all others set
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fff3, 16'h7fff, 64'd300,
                    END_VALUE, CHECK_VALUE);
        // number going back
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fff0, 16'h0000, 64'd301,
                    END_VALUE, CHECK_VALUE);
        // foreign id: no timeout, no continuity, timestamp at full scale
        queue_frame(SOF_WORD, 7'h7f, 64'd0, 16'hffff, 64'hffff_ffff_ffff_ffff,
                    END_VALUE, CHECK_VALUE);
        // gap of four, timestamp wraps round to zero
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fff5, 16'h0000, 64'd0,
                    END_VALUE, CHECK_VALUE);
        // bad start words
        queue_frame(16'h0000, 7'h00, 64'hffff_ffff_ffff_fff6, 16'h0000, 64'd10,
                    END_VALUE, CHECK_VALUE);
        queue_frame(16'hffff, 7'h00, 64'hffff_ffff_ffff_fff7, 16'h0000, 64'd20,
                    END_VALUE, CHECK_VALUE);
        // trailer words, good and bad
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fff8, 16'h0000, 64'd30,
                    16'h0000, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fff9, 16'h0000, 64'd40,
                    16'hfffb, 16'hffff);
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fffa, 16'h0000, 64'd50,
                    16'hfffb, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fffb, 16'h0000, 64'd60,
                    END_VALUE, 16'h0000);
        // large timestamp steps both ways
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fffc, 16'h0000,
                    64'h8000_0000_0000_0000, END_VALUE, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_fffd, 16'h0000,
                    64'h7fff_ffff_ffff_ffff, END_VALUE, CHECK_VALUE);
        // top of the number range, then wrap to zero
        queue_frame(SOF_WORD, 7'h00, 64'hffff_ffff_ffff_ffff, 16'h0000, 64'd5,
                    END_VALUE, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h00, 64'd0, 16'h0000, 64'd6, END_VALUE, CHECK_VALUE);
        drain_frames();

        gen_frame_no = 64'd0;
        gen_stamp    = 64'd6;
        run_random(RANDOM_CHUNK);
        run_random(RANDOM_CHUNK);

        // phase two: heavy gaps on requests, light back pressure
        send_idle_pct = 79;
        recv_idle_pct = 19;
        write_fe_id(7'h7f);
        run_random(RANDOM_CHUNK);
        run_random(RANDOM_CHUNK);

        // phase three: both sides flat out
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_fe_id(7'h55);
        run_random(RANDOM_CHUNK);
        run_random(RANDOM_CHUNK);

        // gap of exactly full scale, then a saturating one; lost total sticks
        queue_frame(SOF_WORD, 7'h55, 64'd0, 16'h8000, 64'd1000, END_VALUE, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h55, 64'h0000_0001_0000_0000, 16'h0000, 64'd2000,
                    END_VALUE, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h55, 64'hffff_ffff_ffff_ffff, 16'h0000, 64'd3000,
                    END_VALUE, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h55, 64'd0, 16'h0000, 64'd4000, END_VALUE, CHECK_VALUE);
        queue_frame(SOF_WORD, 7'h55, 64'd3, 16'h0000, 64'd5000, END_VALUE, CHECK_VALUE);
        drain_frames();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
